// ===== sv/bfhd_pkg.sv =====
package bfhd_pkg;

	// Line geometry
	localparam int MAX_WIDTH  = 2048;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = COL_W + 1;
	localparam int NUM_CH     = 4;

	// Fixed register and field widths
	localparam int IMG_WIDTH_W  = 12;
	localparam int IMG_HEIGHT_W = 16;
	localparam int FMT_W        = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int PIX_W        = 8;
	localparam int PAIR_W       = PIX_W + 1;
	localparam int TOTAL_W      = PIX_W + 2;

	// Reset values of the configuration registers
	localparam logic [IMG_WIDTH_W-1:0]  IMG_WIDTH_RST  = IMG_WIDTH_W'(2048);
	localparam logic [IMG_HEIGHT_W-1:0] IMG_HEIGHT_RST = IMG_HEIGHT_W'(2048);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMG_WIDTH    = 2'd0,
		REG_IMG_HEIGHT   = 2'd1,
		REG_PIXEL_FORMAT = 2'd2
	} bfhd_reg_t;

	typedef enum logic [FMT_W-1:0] {
		FMT_GRAY = 2'd0,
		FMT_RGB  = 2'd1,
		FMT_RGBA = 2'd2
	} bfhd_fmt_t;

	typedef logic [NUM_CH-1:0][PIX_W-1:0]  bfhd_pix_t;
	typedef logic [NUM_CH-1:0][PAIR_W-1:0] bfhd_pair_t;

	// Line buffer request issued at the edge that accepts a pixel
	typedef struct packed {
		logic               we;
		logic               re;
		logic [LINE_AW-1:0] addr;
	} bfhd_ram_req_t;

	// What a pixel leaves for the vertical stage
	typedef struct packed {
		logic              emit;
		logic              h_one;
		logic              last;
		logic [NUM_CH-1:0] mask;
	} bfhd_step_t;

	// Pipeline status seen by the top level
	typedef struct packed {
		logic s1_valid;
		logic s1_move;
	} bfhd_pipe_stat_t;

	// Active channel lanes for a format code; the unassigned code means four
	function automatic logic [NUM_CH-1:0] chan_mask(input logic [FMT_W-1:0] fmt);
		logic [NUM_CH-1:0] m;
		case (fmt)
			FMT_GRAY: m = 4'b0001;
			FMT_RGB:  m = 4'b0111;
			default:  m = 4'b1111;
		endcase
		return m;
	endfunction

endpackage

// ===== sv/bfhd_line_ram.sv =====
module bfhd_line_ram (
	input  logic                  clk,
	input  bfhd_pkg::bfhd_ram_req_t req,
	input  bfhd_pkg::bfhd_pair_t  wdata,
	output bfhd_pkg::bfhd_pair_t  rdata
);
	import bfhd_pkg::*;

	bfhd_pair_t mem [LINE_DEPTH];
	bfhd_pair_t rdata_q;

	// Write pair sums of an even row
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= wdata;
		end
	end

	// Read for the odd row; hold the data until the next read
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/bfhd_raster.sv =====
module bfhd_raster (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    accept,
	input  bfhd_pkg::bfhd_pix_t                     pix,
	input  logic [bfhd_pkg::IMG_WIDTH_W-1:0]        img_width,
	input  logic [bfhd_pkg::IMG_HEIGHT_W-1:0]       img_height,
	input  logic [bfhd_pkg::FMT_W-1:0]              pixel_format,
	output bfhd_pkg::bfhd_ram_req_t                 ram_req,
	output bfhd_pkg::bfhd_pair_t                    pair,
	output bfhd_pkg::bfhd_step_t                    step
);
	import bfhd_pkg::*;

	logic [COL_W-1:0]          col_q;
	logic [IMG_HEIGHT_W-1:0]   row_q;
	bfhd_pix_t                 held_q;

	logic [WID_W-1:0]          eff_w;
	logic [IMG_HEIGHT_W-1:0]   eff_h;
	logic                      w_one;
	logic                      h_one;
	logic [COL_W-1:0]          half_w;
	logic [IMG_HEIGHT_W-2:0]   half_h;
	logic                      col_in_pairs;
	logic                      row_in_pairs;
	logic                      have_pair;
	logic                      hold_left;
	logic [LINE_AW-1:0]        k;
	logic [LINE_AW-1:0]        outw_m1;
	logic [IMG_HEIGHT_W-2:0]   oy;
	logic [IMG_HEIGHT_W-2:0]   outh_m1;
	logic                      row_end;
	logic                      img_end;

	// Clamp the image size
	always_comb begin
		if (img_width == '0) begin
			eff_w = WID_W'(1);
		end else if (32'(img_width) > MAX_WIDTH) begin
			eff_w = WID_W'(MAX_WIDTH);
		end else begin
			eff_w = WID_W'(img_width);
		end
		eff_h = (img_height == '0) ? IMG_HEIGHT_W'(1) : img_height;
	end

	assign w_one  = (eff_w == WID_W'(1));
	assign h_one  = (eff_h == IMG_HEIGHT_W'(1));
	assign half_w = eff_w[WID_W-1:1];
	assign half_h = eff_h[IMG_HEIGHT_W-1:1];

	// Horizontal pairing
	assign col_in_pairs = ({1'b0, col_q} < {half_w, 1'b0});
	assign hold_left    = !w_one && col_in_pairs && !col_q[0];
	assign have_pair    = w_one || (col_in_pairs && col_q[0]);
	assign k            = w_one ? '0 : col_q[COL_W-1:1];

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			if (w_one) begin
				pair[i] = {pix[i], 1'b0};
			end else begin
				pair[i] = PAIR_W'(held_q[i]) + PAIR_W'(pix[i]);
			end
		end
	end

	// Vertical pairing: even rows park in the line, odd rows read it back
	assign row_in_pairs = ({1'b0, row_q} < {1'b0, half_h, 1'b0});

	always_comb begin
		ram_req.addr = k;
		ram_req.we   = accept && have_pair && !h_one && row_in_pairs && !row_q[0];
		ram_req.re   = accept && have_pair && !h_one && row_in_pairs && row_q[0];
	end

	// Last output pixel of the reduced image
	assign outw_m1 = w_one ? '0 : LINE_AW'(half_w - COL_W'(1));
	assign oy      = h_one ? '0 : row_q[IMG_HEIGHT_W-1:1];
	assign outh_m1 = h_one ? '0 : (half_h - (IMG_HEIGHT_W-1)'(1));

	always_comb begin
		step.emit  = have_pair && (h_one || (row_in_pairs && row_q[0]));
		step.h_one = h_one;
		step.last  = (k == outw_m1) && (oy == outh_m1);
		step.mask  = chan_mask(pixel_format);
	end

	// Raster counters; a counter past a shrunken limit also wraps
	assign row_end = ({1'b0, col_q} >= (eff_w - WID_W'(1)));
	assign img_end = (row_q >= (eff_h - IMG_HEIGHT_W'(1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_q + IMG_HEIGHT_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Hold the even-column pixel of the current pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (accept && hold_left) begin
			held_q <= pix;
		end
	end

endmodule

// ===== sv/bfhd_vsum.sv =====
module bfhd_vsum (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  bfhd_pkg::bfhd_step_t      step,
	input  bfhd_pkg::bfhd_pair_t      pair,
	input  bfhd_pkg::bfhd_pair_t      line_data,
	input  logic                      out_stall,
	output logic                      in_stall,
	output logic                      out_valid,
	output bfhd_pkg::bfhd_pix_t       out_pix,
	output logic                      out_last,
	output bfhd_pkg::bfhd_pipe_stat_t stat
);
	import bfhd_pkg::*;

	logic                valid_s1;
	bfhd_pair_t          pair_s1;
	logic                h_one_s1;
	logic                last_s1;
	logic [NUM_CH-1:0]   mask_s1;
	logic                out_valid_q;
	bfhd_pix_t           out_pix_q;
	logic                out_last_q;
	logic                s1_move;
	bfhd_pix_t           avg;

	// Stage 1 drains into the output register when that is free or taken
	assign s1_move  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= step.emit;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pair_s1  <= pair;
			h_one_s1 <= step.h_one;
			last_s1  <= step.last;
			mask_s1  <= step.mask;
		end
	end

	// Add the parked row and truncate the sum of four
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			logic [TOTAL_W-1:0] total;
			if (h_one_s1) begin
				total = {pair_s1[i], 1'b0};
			end else begin
				total = TOTAL_W'(line_data[i]) + TOTAL_W'(pair_s1[i]);
			end
			avg[i] = mask_s1[i] ? total[TOTAL_W-1:2] : '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_pix_q  <= avg;
			out_last_q <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_last  = out_last_q;

	always_comb begin
		stat.s1_valid = valid_s1;
		stat.s1_move  = s1_move;
	end

endmodule

// ===== sv/box_filter_half_downsample_unit.sv =====
// 2x2 box-filter downsampler producing one half-size mipmap level. Source pixels
// enter in raster order, one per clock unless in_stall holds them, with no
// bubbles between rows or images; each 2x2 block leaves as the truncated
// average through stage 1 and the output register. Throughput is set by
// the line buffer, a 1024 x 36-bit memory that takes one write (even rows) or
// one read (odd rows) per cycle and holds the horizontal pair sums. The line
// buffer needs no clearing after reset. Write the image width, image height and
// pixel format registers only while the block is idle; an odd last column or
// row is dropped, a width or height of one is replicated, and inactive channels
// read as zero. The raster counters wrap after the last source pixel, so images
// may follow one another directly.
module box_filter_half_downsample_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bfhd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bfhd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          in_ch0,
	input  logic [7:0]                          in_ch1,
	input  logic [7:0]                          in_ch2,
	input  logic [7:0]                          in_ch3,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [7:0]                          out_ch0,
	output logic [7:0]                          out_ch1,
	output logic [7:0]                          out_ch2,
	output logic [7:0]                          out_ch3,
	output logic                                last_of_image
);
	import bfhd_pkg::*;

	logic [IMG_WIDTH_W-1:0]  img_width_q;
	logic [IMG_HEIGHT_W-1:0] img_height_q;
	logic [FMT_W-1:0]        pixel_format_q;
	logic                    accept;
	bfhd_pix_t               pix;
	bfhd_pix_t               out_pix;
	bfhd_pair_t              pair;
	bfhd_pair_t              line_data;
	bfhd_ram_req_t           ram_req;
	bfhd_step_t              step;
	bfhd_pipe_stat_t         stat;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q    <= IMG_WIDTH_RST;
			img_height_q   <= IMG_HEIGHT_RST;
			pixel_format_q <= FMT_RGBA;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMG_WIDTH:    img_width_q    <= cfg_data[IMG_WIDTH_W-1:0];
				REG_IMG_HEIGHT:   img_height_q   <= cfg_data[IMG_HEIGHT_W-1:0];
				REG_PIXEL_FORMAT: pixel_format_q <= cfg_data[FMT_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = in_valid && !in_stall;
	assign pix    = {in_ch3, in_ch2, in_ch1, in_ch0};

	bfhd_raster u_raster (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.pix          (pix),
		.img_width    (img_width_q),
		.img_height   (img_height_q),
		.pixel_format (pixel_format_q),
		.ram_req      (ram_req),
		.pair         (pair),
		.step         (step)
	);

	bfhd_line_ram u_line_ram (
		.clk   (clk),
		.req   (ram_req),
		.wdata (pair),
		.rdata (line_data)
	);

	bfhd_vsum u_vsum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.step      (step),
		.pair      (pair),
		.line_data (line_data),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_pix   (out_pix),
		.out_last  (last_of_image),
		.stat      (stat)
	);

	assign out_ch0 = out_pix[0];
	assign out_ch1 = out_pix[1];
	assign out_ch2 = out_pix[2];
	assign out_ch3 = out_pix[3];

`ifndef SYNTHESIS
	// Line buffer is never written and read in one cycle
	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("line buffer write and read in the same cycle");

	// Line reads only for pixels that produce a result
	a_read_emits: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.re |-> step.emit)
		else $error("line read without a result");

	// Input backpressure only while stage 1 is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (stat.s1_valid && !stat.s1_move))
		else $error("input stalled with stage 1 free");

	// A result-bearing transaction reaches stage 1
	a_emit_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && step.emit) |=> stat.s1_valid)
		else $error("result lost after input transaction");

	// A stage 1 result that moves shows up at the output
	a_move_out: assert property (@(posedge clk) disable iff (!arst_n)
		stat.s1_move |=> out_valid)
		else $error("stage 1 result did not reach the output");
`endif

endmodule
